// File: src/fcs_pkg.sv
// Shared types and constants for the flow-export sequence checker.
// No dependencies; used by every module in src except fcs_ram.
package fcs_pkg;

  // Widths fixed by the item format
  localparam int ENGINE_KEY_W            = 16;
  localparam int ENGINE_KEY_BITS_DEFAULT = 16;
  localparam int QUOT_W                  = 23;  // 32-bit value / 1000 fits here
  localparam int WALL_MS_W               = 11;  // 30-bit ns / 1e6 fits here
  localparam int MS_W                    = 10;  // milliseconds 0..999
  localparam int CFG_INDEX_BITS          = 4;
  localparam int CFG_DATA_BITS           = 17;

  // Item kinds
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_RECORD = 1'b1;

  // Register map
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_FLOWS       = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INTERFACE_LIMIT = 4'd1;

  localparam logic [15:0] MAX_FLOWS_RESET       = 16'd30;
  localparam logic [16:0] INTERFACE_LIMIT_RESET = 17'h10000;

  // Reciprocal constants: x/1000 = (x*M)>>38, x/1e6 = (x*M)>>50, exact for 32-bit x
  localparam logic [28:0] DIV_MS_MAGIC = 29'd274877907;
  localparam int          DIV_MS_SHIFT = 38;
  localparam logic [30:0] DIV_NS_MAGIC = 31'd1125899907;
  localparam int          DIV_NS_SHIFT = 50;

  localparam logic [MS_W-1:0]   MS_PER_S_10  = 10'd1000;
  localparam logic [MS_W:0]     MS_PER_S_11  = 11'd1000;
  localparam logic [MS_W-1:0]   MS_MAX       = 10'd999;

  typedef struct packed {
    logic        mode;
    logic [15:0] flow_count;
    logic [15:0] engine_key;
    logic [31:0] sequence_req;
    logic [31:0] time_first;
    logic [31:0] time_second;
    logic [29:0] nanoseconds;
    logic [31:0] packets;
    logic [31:0] octets;
    logic [15:0] in_interface;
    logic [15:0] out_interface;
  } item_t;

  typedef struct packed {
    logic               header_rejected;
    logic               record_valid;
    logic               out_of_order;
    logic               new_engine;
    logic signed [31:0] missing_records;
    logic [31:0]        start_seconds;
    logic [31:0]        end_seconds;
  } result_t;

  // Item with its divided-down times, ready for the execute stage
  typedef struct packed {
    item_t             item;
    logic [QUOT_W-1:0] q_first;
    logic [QUOT_W-1:0] q_second;
    logic [MS_W-1:0]   r_first;
    logic [MS_W-1:0]   r_second;
    logic [MS_W-1:0]   wall_ms;
  } prep_t;

  // Engine table entry and write request
  typedef struct packed {
    logic        seen;
    logic [31:0] expected;
  } tbl_entry_t;

  typedef struct packed {
    logic                    en;
    logic [ENGINE_KEY_W-1:0] key;
    logic [31:0]             expected;
  } tbl_wr_t;

endpackage

// File: src/fcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fcs_prep.sv
// Front stages: divides uptimes by 1000 and nanoseconds by 1e6 via reciprocals.
// Depends on fcs_pkg.
module fcs_prep (
  input  logic           clk,
  input  logic           load1,
  input  fcs_pkg::item_t item,
  input  logic           load2,
  output fcs_pkg::prep_t prep
);

  logic [60:0]                   prod_first;
  logic [60:0]                   prod_second;
  logic [60:0]                   prod_ns;
  fcs_pkg::item_t                s1_item;
  logic [fcs_pkg::QUOT_W-1:0]    s1_q_first;
  logic [fcs_pkg::QUOT_W-1:0]    s1_q_second;
  logic [fcs_pkg::WALL_MS_W-1:0] s1_wall_ms;

  // Reciprocal multiplies, quotient registered straight after
  assign prod_first  = 61'(item.time_first) * 61'(fcs_pkg::DIV_MS_MAGIC);
  assign prod_second = 61'(item.time_second) * 61'(fcs_pkg::DIV_MS_MAGIC);
  assign prod_ns     = 61'(item.nanoseconds) * 61'(fcs_pkg::DIV_NS_MAGIC);

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_item     <= item;
      s1_q_first  <= prod_first[fcs_pkg::DIV_MS_SHIFT +: fcs_pkg::QUOT_W];
      s1_q_second <= prod_second[fcs_pkg::DIV_MS_SHIFT +: fcs_pkg::QUOT_W];
      s1_wall_ms  <= prod_ns[fcs_pkg::DIV_NS_SHIFT +: fcs_pkg::WALL_MS_W];
    end
  end

  // Remainders need only the low ten bits, as they stay below 1000
  always_ff @(posedge clk) begin
    if (load2) begin
      prep.item     <= s1_item;
      prep.q_first  <= s1_q_first;
      prep.q_second <= s1_q_second;
      prep.r_first  <= s1_item.time_first[9:0]
                       - 10'(s1_q_first[9:0] * fcs_pkg::MS_PER_S_10);
      prep.r_second <= s1_item.time_second[9:0]
                       - 10'(s1_q_second[9:0] * fcs_pkg::MS_PER_S_10);
      prep.wall_ms  <= (s1_wall_ms > 11'(fcs_pkg::MS_MAX)) ? fcs_pkg::MS_MAX
                                                           : s1_wall_ms[9:0];
    end
  end

endmodule

// File: src/fcs_table.sv
// Per-engine table: seen mark and expected sequence in one RAM, clearing
// sweep after reset, and forwarding of writes made while a read is in flight.
// Depends on fcs_pkg and fcs_ram.
module fcs_table #(
  parameter int ENGINE_KEY_BITS = fcs_pkg::ENGINE_KEY_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [fcs_pkg::ENGINE_KEY_W-1:0]  rd_key,
  input  logic                              adv,
  input  fcs_pkg::tbl_wr_t                  wr,
  output logic                              clearing,
  output fcs_pkg::tbl_entry_t               entry
);

  localparam int DEPTH = 1 << ENGINE_KEY_BITS;

  logic [ENGINE_KEY_BITS-1:0] clear_addr;
  logic [ENGINE_KEY_BITS-1:0] rkey;
  logic [ENGINE_KEY_BITS-1:0] wkey;
  logic [ENGINE_KEY_BITS-1:0] s1_key;
  logic                       ram_we;
  logic [ENGINE_KEY_BITS-1:0] ram_waddr;
  fcs_pkg::tbl_entry_t        ram_wdata;
  fcs_pkg::tbl_entry_t        ram_rdata;
  fcs_pkg::tbl_entry_t        wr_entry;
  logic                       s1_fwd;
  fcs_pkg::tbl_entry_t        s1_fwd_entry;

  assign rkey     = rd_key[ENGINE_KEY_BITS-1:0];
  assign wkey     = wr.key[ENGINE_KEY_BITS-1:0];
  assign wr_entry = '{seen: 1'b1, expected: wr.expected};

  // Clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ENGINE_KEY_BITS'(1);
      if (clear_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing | wr.en;
  assign ram_waddr = clearing ? clear_addr : wkey;
  assign ram_wdata = clearing ? '0 : wr_entry;

  fcs_ram #(
    .WIDTH ($bits(fcs_pkg::tbl_entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rkey),
    .rdata (ram_rdata)
  );

  // Catch a write to the same engine landing on the read edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_key       <= rkey;
      s1_fwd       <= wr.en && (wkey == rkey);
      s1_fwd_entry <= wr_entry;
    end
  end

  // Entry for the execute stage, newest write wins
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr.en && (wkey == s1_key)) begin
        entry <= wr_entry;
      end else if (s1_fwd) begin
        entry <= s1_fwd_entry;
      end else begin
        entry <= ram_rdata;
      end
    end
  end

endmodule

// File: src/fcs_exec.sv
// Execute stage: header checks, boot time, missing count, record checks and
// epoch conversion, with the result register.
// Depends on fcs_pkg.
module fcs_exec (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  fcs_pkg::prep_t      prep,
  input  fcs_pkg::tbl_entry_t entry,
  input  logic [15:0]         max_flows,
  input  logic [16:0]         interface_limit,
  output fcs_pkg::tbl_wr_t    wr,
  output fcs_pkg::result_t    result
);

  logic [31:0]              missing_total;
  logic [31:0]              boot_seconds;
  logic [fcs_pkg::MS_W-1:0] boot_ms;
  logic [15:0]              records_left;

  logic [31:0]              missing_next;
  logic [31:0]              boot_seconds_next;
  logic [fcs_pkg::MS_W-1:0] boot_ms_next;
  logic [15:0]              records_left_next;
  logic                     boot_load;
  logic                     borrow;
  logic                     is_header;
  logic                     rejected;
  logic                     seq_low;
  logic                     rec_ok;
  logic                     carry_first;
  logic                     carry_second;
  fcs_pkg::result_t         result_next;

  always_comb begin
    is_header = (prep.item.mode == fcs_pkg::MODE_HEADER);
    rejected  = prep.item.flow_count > max_flows;
    seq_low   = prep.item.sequence_req < entry.expected;

    // Boot time from wall clock minus uptime, borrowing a second
    borrow            = prep.r_first > prep.wall_ms;
    boot_seconds_next = prep.item.time_second - 32'(prep.q_first) - 32'(borrow);
    boot_ms_next      = borrow ? 10'({1'b0, prep.wall_ms} + fcs_pkg::MS_PER_S_11
                                     - {1'b0, prep.r_first})
                               : prep.wall_ms - prep.r_first;

    rec_ok = !(prep.item.time_first > prep.item.time_second)
             && (prep.item.packets != '0) && (prep.item.octets != '0)
             && ({1'b0, prep.item.in_interface} < interface_limit)
             && ({1'b0, prep.item.out_interface} < interface_limit);

    carry_first  = ({1'b0, boot_ms} + {1'b0, prep.r_first}) >= fcs_pkg::MS_PER_S_11;
    carry_second = ({1'b0, boot_ms} + {1'b0, prep.r_second}) >= fcs_pkg::MS_PER_S_11;

    missing_next      = missing_total;
    records_left_next = records_left;
    boot_load         = 1'b0;
    wr.en             = 1'b0;
    wr.key            = prep.item.engine_key;
    wr.expected       = prep.item.sequence_req + 32'(prep.item.flow_count);
    result_next       = '0;

    if (is_header) begin
      if (rejected) begin
        result_next.header_rejected = 1'b1;
        records_left_next           = '0;
      end else begin
        boot_load         = 1'b1;
        records_left_next = prep.item.flow_count;
        if (!entry.seen) begin
          result_next.new_engine = 1'b1;
          wr.en                  = go;
        end else if (seq_low) begin
          result_next.out_of_order = 1'b1;
          missing_next = missing_total - 32'(prep.item.flow_count);
        end else begin
          missing_next = missing_total + (prep.item.sequence_req - entry.expected);
          wr.en        = go;
        end
      end
    end else if (records_left != '0) begin
      records_left_next = records_left - 16'd1;
      if (rec_ok) begin
        result_next.record_valid  = 1'b1;
        result_next.start_seconds = boot_seconds + 32'(prep.q_first) + 32'(carry_first);
        result_next.end_seconds   = boot_seconds + 32'(prep.q_second) + 32'(carry_second);
      end
    end
    result_next.missing_records = signed'(missing_next);
  end

  // Running state
  always_ff @(posedge clk) begin
    if (rst) begin
      missing_total <= '0;
      boot_seconds  <= '0;
      boot_ms       <= '0;
      records_left  <= '0;
    end else if (go) begin
      missing_total <= missing_next;
      records_left  <= records_left_next;
      if (boot_load) begin
        boot_seconds <= boot_seconds_next;
        boot_ms      <= boot_ms_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (go) begin
      result <= result_next;
    end
  end

endmodule

// File: src/flow_export_sequence_checker.sv
// Top level of the flow-export sequence checker: handshakes, stage valids,
// configuration registers. Depends on fcs_pkg, fcs_prep, fcs_table, fcs_exec.
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+---------------------
//  item     | item_valid, item_ready, item              | one header or record
//  result   | result_valid, result_ready, result        | one result per item
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// One item per cycle sustained while result_ready holds high; three register stages
// (divide stage, remainder and table-read stage, execute) lie between item and result.
// After rst the engine table is swept, all 2**ENGINE_KEY_BITS entries (65536 by
// default), with item_ready low; cfg beats are taken throughout.
// A stalled result holds the pipeline; item_ready falls once all stages are full.
module flow_export_sequence_checker #(
  parameter int ENGINE_KEY_BITS = fcs_pkg::ENGINE_KEY_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  fcs_pkg::item_t                       item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output fcs_pkg::result_t                     result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [fcs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic                s1_v;
  logic                s2_v;
  logic                item_fire;
  logic                out_free;
  logic                s2_free;
  logic                s1_free;
  logic                s1_go;
  logic                s2_go;
  logic                tbl_clearing;
  logic [15:0]         max_flows;
  logic [16:0]         interface_limit;
  fcs_pkg::prep_t      prep;
  fcs_pkg::tbl_entry_t entry;
  fcs_pkg::tbl_wr_t    tbl_wr;

  // Stage flow control
  assign out_free   = !result_valid || result_ready;
  assign s2_go      = s2_v && out_free;
  assign s2_free    = !s2_v || out_free;
  assign s1_go      = s1_v && s2_free;
  assign s1_free    = !s1_v || s2_free;
  assign item_ready = s1_free && !tbl_clearing;
  assign item_fire  = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v <= item_fire;
      end
      if (s2_free) begin
        s2_v <= s1_go;
      end
      if (out_free) begin
        result_valid <= s2_go;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_flows       <= fcs_pkg::MAX_FLOWS_RESET;
      interface_limit <= fcs_pkg::INTERFACE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcs_pkg::REG_MAX_FLOWS:       max_flows       <= cfg_data[15:0];
        fcs_pkg::REG_INTERFACE_LIMIT: interface_limit <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  fcs_prep u_prep (
    .clk   (clk),
    .load1 (item_fire),
    .item  (item),
    .load2 (s1_go),
    .prep  (prep)
  );

  fcs_table #(
    .ENGINE_KEY_BITS (ENGINE_KEY_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (item_fire),
    .rd_key   (item.engine_key),
    .adv      (s1_go),
    .wr       (tbl_wr),
    .clearing (tbl_clearing),
    .entry    (entry)
  );

  fcs_exec u_exec (
    .clk             (clk),
    .rst             (rst),
    .go              (s2_go),
    .prep            (prep),
    .entry           (entry),
    .max_flows       (max_flows),
    .interface_limit (interface_limit),
    .wr              (tbl_wr),
    .result          (result)
  );

  // No item taken while the table sweep runs
  a_no_item_in_sweep: assert property (@(posedge clk) disable iff (rst)
    tbl_clearing |-> !item_fire)
    else $error("item accepted during table sweep");

  // Table writes come only from a header leaving the execute stage
  a_write_from_header: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (s2_go && prep.item.mode == fcs_pkg::MODE_HEADER))
    else $error("table write without executing header");

  // A blocked execute stage keeps its item
  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_v && !out_free) |=> s2_v)
    else $error("execute stage lost an item");

  // An accepted item occupies the first stage next cycle
  a_s1_fills: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> s1_v)
    else $error("accepted item missing from first stage");

endmodule
